// ===== sv/winding_span_generator_defines.svh =====
// assertion helpers shared by the span generator modules
`ifndef WINDING_SPAN_GENERATOR_DEFINES_SVH
`define WINDING_SPAN_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define WSG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define WSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/wsg_pkg.sv =====
package wsg_pkg;

   // default widths
   localparam int COORD_BITS_DEF   = 16;
   localparam int WINDING_BITS_DEF = 16;

   // result queue depth, must be a power of two of at least 4
   localparam int QUEUE_DEPTH = 4;

   // input command codes
   localparam logic CMD_FRAG  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // result kind codes
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_SPAN  = 1'b1;

   // results written into the queue for one item
   typedef struct packed {
      logic first;
      logic second;
   } wsg_push_type;

endpackage

// ===== sv/winding_span_generator.sv =====
// Nonzero-winding span generator.
// req channel: one boundary fragment or a flush command per item, sorted by
//   row, then column. Fragments at one pixel are summed into a pending pixel.
// rsp channel: edge pixels (kind 0) and solid spans (kind 1); tlast marks the
//   last result caused by one req item. A fragment that closes a pixel and
//   opens a gap gives the pixel first, then the span.
// Results of an accepted item are written into the result queue, behind any
//   older results, and leave it on rsp. Throughput: one req item per cycle
//   while req_tready is high; the winding update is a single pass between the
//   state registers and a 4-entry result queue. The rsp port drains one result
//   per cycle while rsp_tready is high, so items giving two results fill the queue.
// req_tready is high while the queue has room for two results; when the
//   receiver stalls, the queue fills and req_tready drops, no result is lost.
// Reset (synchronous, active high) clears the winding state and the queue;
//   a flush item closes the pending pixel and returns to the same state.
module winding_span_generator #(
   parameter int COORD_BITS   = wsg_pkg::COORD_BITS_DEF,
   parameter int WINDING_BITS = wsg_pkg::WINDING_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // frag_x, frag_y, wind_sign, crosses_out, crosses_sample, zero pad
   input  logic [((2*COORD_BITS+4+7)/8)*8-1:0]       req_tdata,
   // cmd
   input  logic                                      req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // x_start, x_end, row, zero pad
   output logic [((3*COORD_BITS+7)/8)*8-1:0]         rsp_tdata,
   // kind
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast
);
   import wsg_pkg::*;

   localparam int C          = COORD_BITS;
   localparam int ENTRY_BITS = 3*C + 2;
   localparam int RSP_BITS   = ((3*C+7)/8)*8;

   logic                  accept;
   logic                  room;
   wsg_push_type          push;
   logic [ENTRY_BITS-1:0] entry0;
   logic [ENTRY_BITS-1:0] entry1;
   logic [ENTRY_BITS-1:0] out_entry;

   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   // winding state and result forming
   wsg_core #(
      .COORD_BITS   (COORD_BITS),
      .WINDING_BITS (WINDING_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (req_tuser),
      .frag_x         (req_tdata[C-1:0]),
      .frag_y         (req_tdata[2*C-1:C]),
      .wind_sign      (req_tdata[2*C+1:2*C]),
      .crosses_out    (req_tdata[2*C+2]),
      .crosses_sample (req_tdata[2*C+3]),
      .push           (push),
      .entry0         (entry0),
      .entry1         (entry1)
   );

   // result queue toward the rsp channel
   wsg_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry0    (entry0),
      .entry1    (entry1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry)
   );

   // unpack last, kind, row, x_end, x_start
   assign rsp_tdata = RSP_BITS'(out_entry[3*C-1:0]);
   assign rsp_tuser = out_entry[3*C];
   assign rsp_tlast = out_entry[3*C+1];

endmodule

// ===== sv/wsg_core.sv =====
`include "winding_span_generator_defines.svh"

module wsg_core #(
   parameter int COORD_BITS   = 16,
   parameter int WINDING_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           cmd,
   input  logic signed [COORD_BITS-1:0]   frag_x,
   input  logic signed [COORD_BITS-1:0]   frag_y,
   input  logic signed [1:0]              wind_sign,
   input  logic                           crosses_out,
   input  logic                           crosses_sample,
   output wsg_pkg::wsg_push_type          push,
   output logic [3*COORD_BITS+1:0]        entry0,
   output logic [3*COORD_BITS+1:0]        entry1
);
   import wsg_pkg::*;

   localparam int C = COORD_BITS;
   localparam int W = WINDING_BITS;

   // winding state
   logic signed [W-1:0] row_winding_ff,    row_winding_in;
   logic signed [C-1:0] current_row_ff,    current_row_in;
   logic signed [C:0]   next_free_col_ff,  next_free_col_in;
   logic signed [C-1:0] pend_col_ff,       pend_col_in;
   logic signed [C-1:0] pend_row_ff,       pend_row_in;
   logic signed [W-1:0] pend_out_ff,       pend_out_in;
   logic signed [W-1:0] pend_smp_ff,       pend_smp_in;
   logic                pend_valid_ff,     pend_valid_in;

   logic signed [W-1:0] sign_ext;
   logic signed [W-1:0] d_out;
   logic signed [W-1:0] d_smp;
   logic                same_pixel;
   logic                is_flush;
   logic                closing;
   logic signed [W:0]   smp_sum;
   logic                emit_px;
   logic signed [W-1:0] rw_closed;
   logic signed [C:0]   nfc_closed;
   logic signed [C:0]   x_wide;
   logic                new_row;
   logic                emit_span;
   logic                px_last;
   logic [3*C+1:0]      px_entry;
   logic [3*C+1:0]      span_entry;

   // clamp a one-bit-grown winding sum back to the winding range
   function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
      logic signed [W-1:0] r;
      if (v[W] != v[W-1]) begin
         r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   // per-fragment deltas
   assign sign_ext = {{(W-2){wind_sign[1]}}, wind_sign};
   assign d_out    = crosses_out    ? sign_ext : '0;
   assign d_smp    = crosses_sample ? sign_ext : '0;

   assign is_flush   = (cmd == CMD_FLUSH);
   assign same_pixel = pend_valid_ff && (frag_x == pend_col_ff) && (frag_y == pend_row_ff);
   assign closing    = pend_valid_ff && (is_flush || !same_pixel);

   // close the pending pixel
   assign smp_sum    = {row_winding_ff[W-1], row_winding_ff} + {pend_smp_ff[W-1], pend_smp_ff};
   assign emit_px    = closing && (smp_sum != '0);
   assign rw_closed  = closing
                     ? sat_w({row_winding_ff[W-1], row_winding_ff} + {pend_out_ff[W-1], pend_out_ff})
                     : row_winding_ff;
   assign nfc_closed = closing ? ({pend_col_ff[C-1], pend_col_ff} + (C+1)'(1)) : next_free_col_ff;

   // gap left of the new pixel on the same row
   assign x_wide    = {frag_x[C-1], frag_x};
   assign new_row   = (frag_y != current_row_ff);
   assign emit_span = !is_flush && !same_pixel && !new_row
                    && (x_wide > nfc_closed) && (rw_closed != '0);

   // result entries: last, kind, row, x_end, x_start
   assign px_last    = is_flush || !emit_span;
   assign px_entry   = {px_last, KIND_PIXEL, pend_row_ff, pend_col_ff + C'(1), pend_col_ff};
   assign span_entry = {1'b1, KIND_SPAN, current_row_ff, frag_x, nfc_closed[C-1:0]};

   assign entry0      = emit_px ? px_entry : span_entry;
   assign entry1      = span_entry;
   assign push.first  = accept && (emit_px || emit_span);
   assign push.second = accept && emit_px && emit_span;

   // next state
   always_comb begin
      row_winding_in   = row_winding_ff;
      current_row_in   = current_row_ff;
      next_free_col_in = next_free_col_ff;
      pend_col_in      = pend_col_ff;
      pend_row_in      = pend_row_ff;
      pend_out_in      = pend_out_ff;
      pend_smp_in      = pend_smp_ff;
      pend_valid_in    = pend_valid_ff;
      if (accept) begin
         if (is_flush) begin
            row_winding_in   = '0;
            current_row_in   = '0;
            next_free_col_in = '0;
            pend_col_in      = '0;
            pend_row_in      = '0;
            pend_out_in      = '0;
            pend_smp_in      = '0;
            pend_valid_in    = 1'b0;
         end else if (same_pixel) begin
            pend_out_in = sat_w({pend_out_ff[W-1], pend_out_ff} + {d_out[W-1], d_out});
            pend_smp_in = sat_w({pend_smp_ff[W-1], pend_smp_ff} + {d_smp[W-1], d_smp});
         end else begin
            row_winding_in   = new_row ? '0 : rw_closed;
            current_row_in   = frag_y;
            next_free_col_in = nfc_closed;
            pend_col_in      = frag_x;
            pend_row_in      = frag_y;
            pend_out_in      = d_out;
            pend_smp_in      = d_smp;
            pend_valid_in    = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_winding_ff   <= '0;
         current_row_ff   <= '0;
         next_free_col_ff <= '0;
         pend_col_ff      <= '0;
         pend_row_ff      <= '0;
         pend_out_ff      <= '0;
         pend_smp_ff      <= '0;
         pend_valid_ff    <= 1'b0;
      end else begin
         row_winding_ff   <= row_winding_in;
         current_row_ff   <= current_row_in;
         next_free_col_ff <= next_free_col_in;
         pend_col_ff      <= pend_col_in;
         pend_row_ff      <= pend_row_in;
         pend_out_ff      <= pend_out_in;
         pend_smp_ff      <= pend_smp_in;
         pend_valid_ff    <= pend_valid_in;
      end
   end

   // checks
   `WSG_ASSERT_NEXT(a_flush_clears, accept && is_flush, !pend_valid_ff && row_winding_ff == '0, "flush left a pending pixel or winding")
   `WSG_ASSERT_NEXT(a_frag_pends, accept && !is_flush, pend_valid_ff, "fragment left no pending pixel")
   `WSG_ASSERT_NOW(a_pend_on_row, pend_valid_ff, pend_row_ff == current_row_ff, "pending pixel off the current row")

endmodule

// ===== sv/wsg_queue.sv =====
`include "winding_span_generator_defines.svh"

module wsg_queue #(
   parameter int ENTRY_BITS = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wsg_pkg::wsg_push_type   push,
   input  logic [ENTRY_BITS-1:0]   entry0,
   input  logic [ENTRY_BITS-1:0]   entry1,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [ENTRY_BITS-1:0]   out_entry
);
   import wsg_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [ENTRY_BITS-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff,  count_in;
   logic [PTR_BITS-1:0]   wr_ptr_next;
   logic [1:0]            n_push;
   logic                  pop;

   // room for the two results one item may give
   assign room      = (count_ff <= (PTR_BITS+1)'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_entry = store_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // pointer and fill bookkeeping
   assign n_push      = {1'b0, push.first} + {1'b0, push.second};
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_BITS'(n_push);
   assign rd_ptr_in   = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in    = count_ff + (PTR_BITS+1)'(n_push) - (PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.first) begin
         store_ff[wr_ptr_ff] <= entry0;
      end
      if (push.second) begin
         store_ff[wr_ptr_next] <= entry1;
      end
   end

   // checks
   `WSG_ASSERT_NOW(a_no_overflow, 1'b1, count_ff <= (PTR_BITS+1)'(QUEUE_DEPTH), "result queue overflow")
   `WSG_ASSERT_NOW(a_push_with_room, push.first || push.second, room, "results pushed without room")
   `WSG_ASSERT_NOW(a_second_after_first, push.second, push.first, "second result without first")
   `WSG_ASSERT_NOW(a_empty_ptrs, count_ff == '0, rd_ptr_ff == wr_ptr_ff, "empty queue with split pointers")

endmodule

// ===== tb/sv/winding_span_checker.sv =====
// watches both channels of the span generator, predicts every result item
// and compares it with what comes out of the rsp channel
module winding_span_checker #(
   parameter int CW = wsg_pkg::COORD_BITS_DEF,
   parameter int WW = wsg_pkg::WINDING_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // frag_x, frag_y, wind_sign, crosses_out, crosses_sample, zero pad
   input  logic [((2*CW+4+7)/8)*8-1:0]       req_tdata,
   // cmd
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // x_start, x_end, row, zero pad
   input  logic [((3*CW+7)/8)*8-1:0]         rsp_tdata,
   // kind
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                fail_count,
   output int                                open_count,
   output int                                pixel_count,
   output int                                span_count
);
   import wsg_pkg::*;

   localparam int REQ_W = ((2*CW+4+7)/8)*8;
   localparam logic signed [WW+1:0] WIND_MAX = (WW+2)'((1 <<< (WW-1)) - 1);
   localparam logic signed [WW+1:0] WIND_MIN = (WW+2)'(-(1 <<< (WW-1)));

   typedef struct {
      logic          kind;
      logic [CW-1:0] x_start;
      logic [CW-1:0] x_end;
      logic [CW-1:0] row;
      logic          last;
   } span_result_type;

   // results still owed by the block, oldest first
   span_result_type upcoming_spans[$];
   // results caused by the item being predicted
   span_result_type caused[$];

   // predicted block state
   logic signed [WW-1:0] row_winding;
   logic signed [CW-1:0] current_row;
   logic signed [CW:0]   next_free;
   logic signed [CW-1:0] pend_col;
   logic signed [CW-1:0] pend_row;
   logic signed [WW-1:0] pend_out;
   logic signed [WW-1:0] pend_sample;
   logic                 pend_valid;

   int mismatches = 0;
   int pixels_seen = 0;
   int spans_seen = 0;

   function automatic logic signed [WW-1:0] clamp_winding(input logic signed [WW+1:0] v);
      if (v > WIND_MAX)
         return WIND_MAX[WW-1:0];
      if (v < WIND_MIN)
         return WIND_MIN[WW-1:0];
      return v[WW-1:0];
   endfunction

   task automatic clear_winding();
      row_winding = '0;
      current_row = '0;
      next_free   = '0;
      pend_col    = '0;
      pend_row    = '0;
      pend_out    = '0;
      pend_sample = '0;
      pend_valid  = 1'b0;
   endtask

   // close the pending pixel: edge pixel if covered, then fold in its out delta
   task automatic close_pending();
      logic signed [WW+1:0] wide;
      span_result_type r;
      if (pend_valid) begin
         wide = row_winding + pend_sample;
         if (wide != 0) begin
            r.kind    = KIND_PIXEL;
            r.x_start = pend_col;
            r.x_end   = pend_col + CW'(1);
            r.row     = pend_row;
            r.last    = 1'b0;
            caused.insert(caused.size(), r);
         end
         wide = row_winding + pend_out;
         row_winding = clamp_winding(wide);
         next_free   = {pend_col[CW-1], pend_col} + (CW+1)'(1);
         pend_valid  = 1'b0;
      end
   endtask

   // one accepted req item: update the winding state, queue what it causes
   task automatic advance_winding(input logic cmd, input logic [REQ_W-1:0] data);
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [1:0]    s;
      logic signed [WW-1:0] d_out;
      logic signed [WW-1:0] d_smp;
      logic signed [WW+1:0] wide;
      span_result_type r;
      caused.delete();
      x = data[CW-1:0];
      y = data[2*CW-1:CW];
      s = data[2*CW+1:2*CW];
      d_out = data[2*CW+2] ? WW'(s) : '0;
      d_smp = data[2*CW+3] ? WW'(s) : '0;
      if (cmd == CMD_FLUSH) begin
         close_pending();
         clear_winding();
      end else if (pend_valid && x == pend_col && y == pend_row) begin
         // same pixel: sum into the pending deltas
         wide = pend_out + d_out;
         pend_out = clamp_winding(wide);
         wide = pend_sample + d_smp;
         pend_sample = clamp_winding(wide);
      end else begin
         close_pending();
         if (y != current_row) begin
            row_winding = '0;
            current_row = y;
         end else if (x > next_free && row_winding != 0) begin
            // covered gap left of the new pixel
            r.kind    = KIND_SPAN;
            r.x_start = next_free[CW-1:0];
            r.x_end   = x;
            r.row     = current_row;
            r.last    = 1'b0;
            caused.insert(caused.size(), r);
         end
         pend_col    = x;
         pend_row    = y;
         pend_out    = d_out;
         pend_sample = d_smp;
         pend_valid  = 1'b1;
      end
      if (caused.size() > 0)
         caused[caused.size()-1].last = 1'b1;
      foreach (caused[i])
         upcoming_spans.insert(upcoming_spans.size(), caused[i]);
   endtask

   task automatic check_field(input string name, input logic [CW-1:0] want,
                              input logic [CW-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // compare results first, then predict from the item taken at the same edge
   always @(posedge clock) begin : watch
      span_result_type want;
      if (reset) begin
         clear_winding();
         upcoming_spans.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser == KIND_SPAN)
               spans_seen++;
            else
               pixels_seen++;
            if (upcoming_spans.size() == 0) begin
               $error("result item with none expected: kind %0d data %0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = upcoming_spans.pop_front();
               check_field("kind", CW'(want.kind), CW'(rsp_tuser));
               check_field("x_start", want.x_start, rsp_tdata[CW-1:0]);
               check_field("x_end", want.x_end, rsp_tdata[2*CW-1:CW]);
               check_field("row", want.row, rsp_tdata[3*CW-1:2*CW]);
               check_field("last", CW'(want.last), CW'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            advance_winding(req_tuser, req_tdata);
      end
      open_count  <= upcoming_spans.size();
      fail_count  <= mismatches;
      pixel_count <= pixels_seen;
      span_count  <= spans_seen;
   end

endmodule

// ===== tb/sv/winding_span_generator_tb.sv =====
module winding_span_generator_tb;
   import wsg_pkg::*;

   localparam int CW           = COORD_BITS_DEF;
   localparam int REQ_W        = ((2*CW+4+7)/8)*8;
   localparam int RSP_W        = ((3*CW+7)/8)*8;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PCT     = 34;

   // winding sign patterns
   localparam logic [1:0] SIGN_NONE = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG2 = 2'b10;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = CMD_FRAG;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   int fail_count;
   int open_count;
   int pixel_count;
   int span_count;
   int item_count = 0;
   int cycle_count = 0;
   logic quiet = 1'b0;

   winding_span_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   winding_span_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .open_count  (open_count),
      .pixel_count (pixel_count),
      .span_count  (span_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver stalls at random, never during the quiet stretch
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [REQ_W-1:0] pack_frag(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [1:0] s,
                                                  input logic co,
                                                  input logic cs);
      return REQ_W'({cs, co, s, y, x});
   endfunction

   // fragment with every field random
   function automatic logic [REQ_W-1:0] pack_noise();
      return pack_frag(CW'($urandom), CW'($urandom), 2'($urandom), 1'($urandom),
                       1'($urandom));
   endfunction

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return CW'($urandom);
         1: return CW'({1'b0, {(CW-1){1'b1}}}) - CW'($urandom_range(0, 5));
         2: return CW'({1'b1, {(CW-1){1'b0}}}) + CW'($urandom_range(0, 3));
         default: return CW'($urandom_range(0, 40));
      endcase
   endfunction

   function automatic logic [1:0] pick_sign();
      case ($urandom_range(0, 9)) inside
         [0:3]: return SIGN_POS;
         [4:7]: return SIGN_NEG;
         8: return SIGN_NONE;
         default: return SIGN_NEG2;
      endcase
   endfunction

   // present one item, with a random gap first, and wait until it is taken
   task automatic send_item(input logic cmd, input logic [REQ_W-1:0] data);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      item_count++;
   endtask

   // several fragments summed at one pixel
   task automatic send_burst(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [1:0] s, input logic co, input logic cs,
                             input int count);
      for (int i = 0; i < count; i++)
         send_item(CMD_FRAG, pack_frag(x, y, s, co, cs));
   endtask

   // a sorted run of pixels with random content, mostly ended by a flush
   task automatic send_run();
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      int pixels;
      int frags;
      row = pick_coord();
      col = pick_coord();
      pixels = $urandom_range(1, 10);
      for (int p = 0; p < pixels; p++) begin
         frags = $urandom_range(1, 3);
         for (int f = 0; f < frags; f++)
            send_item(CMD_FRAG, pack_frag(col, row, pick_sign(), 1'($urandom),
                                          1'($urandom)));
         if ($urandom_range(0, 5) == 0) begin
            row = row + CW'(1);
            col = pick_coord();
         end else begin
            col = col + CW'($urandom_range(1, 6));
         end
      end
      if ($urandom_range(0, 9) < 7)
         send_item(CMD_FLUSH, pack_noise());
   endtask

   initial begin : stimulus
      int random_start;
      int noise;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: summed pixel with the -2 pattern, pixel then span
      send_item(CMD_FRAG, pack_frag(16'd0, 16'd0, SIGN_POS, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'd0, 16'd0, SIGN_NEG2, 1'b0, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'd3, 16'd0, SIGN_POS, 1'b1, 1'b0));
      // pixel at the last column, its end wraps; then unsorted column
      send_item(CMD_FRAG, pack_frag(16'h7fff, 16'd0, SIGN_NEG, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'h8000, 16'd0, SIGN_NONE, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'h8000, 16'd5, SIGN_POS, 1'b0, 1'b0));
      send_item(CMD_FRAG, pack_frag(16'h8001, 16'd5, SIGN_NEG, 1'b1, 1'b0));
      // flush with a pending pixel, without one, and with junk fields
      send_item(CMD_FLUSH, '0);
      send_item(CMD_FLUSH, '0);
      send_item(CMD_FLUSH, {REQ_W{1'b1}});
      // unsorted column on the same row, then row changes at the extremes
      send_item(CMD_FRAG, pack_frag(16'd5, 16'd0, SIGN_POS, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'd2, 16'd0, SIGN_NEG, 1'b0, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'd2, 16'hffff, SIGN_POS, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'h8000, 16'h8000, SIGN_NEG2, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'h8000, 16'h8000, SIGN_NEG2, 1'b1, 1'b1));
      send_item(CMD_FRAG, pack_frag(16'h7fff, 16'h8000, SIGN_POS, 1'b0, 1'b0));
      send_item(CMD_FRAG, pack_frag(16'h7fff, 16'h7fff, SIGN_POS, 1'b1, 1'b1));
      send_item(CMD_FLUSH, {REQ_W{1'b1}});
      send_item(CMD_FLUSH, '0);

      // summed fragments drive a large negative winding across a gap
      send_burst(16'd10, 16'd1, SIGN_NEG2, 1'b1, 1'b1, 6);
      send_item(CMD_FRAG, pack_frag(16'd12, 16'd1, SIGN_NEG, 1'b1, 1'b0));
      send_item(CMD_FRAG, pack_frag(16'd14, 16'd1, SIGN_POS, 1'b0, 1'b0));
      // and a large positive one
      send_burst(16'd0, 16'd2, SIGN_POS, 1'b1, 1'b1, 8);
      send_item(CMD_FRAG, pack_frag(16'd3, 16'd2, SIGN_POS, 1'b1, 1'b0));
      send_item(CMD_FRAG, pack_frag(16'd6, 16'd2, SIGN_NONE, 1'b0, 1'b0));
      send_item(CMD_FLUSH, '0);

      // random: mostly sorted runs, some noise, one stretch with no stalls
      random_start = item_count;
      while (item_count - random_start < RANDOM_ITEMS) begin
         quiet <= (item_count - random_start >= 250) && (item_count - random_start < 450);
         if ($urandom_range(0, 9) < 8) begin
            send_run();
         end else begin
            noise = $urandom_range(1, 4);
            for (int i = 0; i < noise; i++)
               send_item(1'($urandom_range(0, 9) == 0), pack_noise());
         end
      end
      req_tvalid <= 1'b0;
      quiet <= 1'b0;

      // drain
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items: directed cases, summed-pixel bursts, sorted runs",
               item_count);
      $display("and noise; checked %0d edge pixels and %0d solid spans",
               pixel_count, span_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
